// ----- rtl/lcd_pixel_unpack_palette_core_defines.svh -----
// assertion macros for the lcd pixel unpack core
`ifndef LCD_PIXEL_UNPACK_PALETTE_CORE_DEFINES_SVH
`define LCD_PIXEL_UNPACK_PALETTE_CORE_DEFINES_SVH
`ifndef SYNTH
`define LCDPU_ASSERT_IMPL(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("lcdpu assertion failed");
`define LCDPU_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("lcdpu assertion failed");
`else
`define LCDPU_ASSERT_IMPL(label, cond, prop)
`define LCDPU_ASSERT_NEXT(label, cond, prop)
`endif
`endif

// ----- rtl/lcdpu_pkg.sv -----
// shared types, constants and color functions of the lcd pixel unpack core
`default_nettype none
package lcdpu_pkg;
  localparam int unsigned PALETTE_DEPTH = 256;
  localparam int unsigned PAL_AW = 8;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned NPIX_W = 5;
  localparam int unsigned FRAME_W = 20;

  localparam logic [1:0] ACT_PIXEL = 2'd0;
  localparam logic [1:0] ACT_PALWR = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;

  localparam logic [2:0] REG_PIXEL_MODE = 3'd0;
  localparam logic [2:0] REG_RGB_ORDER = 3'd1;
  localparam logic [2:0] REG_BIG_ENDIAN_BYTES = 3'd2;
  localparam logic [2:0] REG_BIG_ENDIAN_PIXELS = 3'd3;
  localparam logic [2:0] REG_FRAME_PIXELS = 3'd4;

  localparam logic [2:0] MODE_1555 = 3'd4;
  localparam logic [2:0] MODE_888 = 3'd5;
  localparam logic [2:0] MODE_565 = 3'd6;
  localparam logic [2:0] MODE_444 = 3'd7;

  localparam logic [FRAME_W-1:0] FRAME_RESET = 20'd76800;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_PALWR = 2'd1,
    KIND_START = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [2:0]         pixel_mode;
    logic               rgb_order;
    logic               big_endian_bytes;
    logic               big_endian_pixels;
    logic [FRAME_W-1:0] frame_pixels;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    logic [NPIX_W-1:0] last_pix;
    logic [31:0]       word;
    logic [PAL_AW-1:0] pal_index;
    logic [15:0]       pal_value;
  } qentry_t;

  typedef struct packed {
    logic    valid;
    qentry_t entry;
  } qhead_t;

  function automatic logic [15:0] from1555(input logic [15:0] w);
    return w + (w & 16'hFFE0) + {10'b0, w[15], 5'b0};
  endfunction

  function automatic logic [15:0] from888(input logic [31:0] w);
    return {w[23:19], w[15:10], w[7:3]};
  endfunction

  function automatic logic [15:0] from444(input logic [15:0] w);
    return {w[11:8], 1'b0, w[7:4], 2'b0, w[3:0], 1'b0};
  endfunction

  function automatic logic [7:0] widen(input logic [5:0] c);
    return {c, c[5:4]};
  endfunction
endpackage
`default_nettype wire

// ----- rtl/lcdpu_ram.sv -----
// generic single-port-write ram with registered read
`default_nettype none
module lcdpu_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ----- rtl/lcdpu_front.sv -----
// front end: accepts input transfers and classifies them for the queue
`default_nettype none
module lcdpu_front (
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [55:0]          s_tdata,
  input  logic [1:0]           s_tuser,
  input  logic [2:0]           pixel_mode,
  input  logic                 full,
  output logic                 push,
  output lcdpu_pkg::qentry_t   push_data
);
  assign s_tready = !full;
  assign push = s_tvalid && !full;

  always_comb begin
    push_data.word = s_tdata[31:0];
    push_data.pal_index = s_tdata[39:32];
    push_data.pal_value = s_tdata[55:40];
    case (s_tuser)
      lcdpu_pkg::ACT_PIXEL: push_data.kind = lcdpu_pkg::KIND_PIXEL;
      lcdpu_pkg::ACT_PALWR: push_data.kind = lcdpu_pkg::KIND_PALWR;
      lcdpu_pkg::ACT_START: push_data.kind = lcdpu_pkg::KIND_START;
      default:              push_data.kind = lcdpu_pkg::KIND_NONE;
    endcase
    if (!pixel_mode[2]) begin
      push_data.last_pix = lcdpu_pkg::NPIX_W'((6'd32 >> pixel_mode[1:0]) - 6'd1);
    end else if (pixel_mode == lcdpu_pkg::MODE_888) begin
      push_data.last_pix = '0;
    end else begin
      push_data.last_pix = lcdpu_pkg::NPIX_W'(1);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/lcdpu_queue.sv -----
// short item queue between front and back
`default_nettype none
module lcdpu_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lcdpu_pkg::qentry_t push_data,
  output logic               full,
  input  logic               pop,
  output lcdpu_pkg::qhead_t  head
);
  localparam int unsigned PW = $clog2(lcdpu_pkg::QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(lcdpu_pkg::QUEUE_DEPTH + 1);

  lcdpu_pkg::qentry_t slots [lcdpu_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign full = (count == CW'(lcdpu_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];
endmodule
`default_nettype wire

// ----- rtl/lcdpu_back.sv -----
// back end: palette store, pixel sequencer, frame counter and output stage
`default_nettype none
module lcdpu_back #(
  parameter int unsigned COUNT_WIDTH = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  lcdpu_pkg::cfg_t   cfg,
  input  lcdpu_pkg::qhead_t head,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [23:0]       m_tdata,
  output logic              m_tlast
);
  localparam int unsigned EW =
    ((COUNT_WIDTH > lcdpu_pkg::FRAME_W) ? COUNT_WIDTH : lcdpu_pkg::FRAME_W) + 1;

  logic [lcdpu_pkg::NPIX_W-1:0] k;
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic in_frame;
  logic stop_after;
  logic is_pixel;
  logic issue;
  logic pix_last;
  logic pal_mode;
  logic pal_we;

  logic [5:0] pos;
  logic [4:0] sel;
  logic [4:0] bitpos;
  logic [3:0] bpp;
  logic [7:0] mask;
  logic [31:0] shifted;
  logic [lcdpu_pkg::PAL_AW-1:0] pal_idx;
  logic [31:0] wsw;
  logic [15:0] half;
  logic [15:0] x_direct;

  logic [lcdpu_pkg::PALETTE_DEPTH-1:0] pal_valid;
  logic [15:0] ram_q;

  logic p_valid;
  logic p_pal;
  logic p_pal_ok;
  logic [15:0] p_x;
  logic p_last;
  logic p_ready;

  logic o_valid;
  logic o_free;
  logic [23:0] o_data;
  logic o_last;

  logic [15:0] px;
  logic [7:0] r8;
  logic [7:0] g8;
  logic [7:0] b8;

  assign count_inc = (count == '1) ? count : count + COUNT_WIDTH'(1);
  assign in_frame = EW'(count) < EW'(cfg.frame_pixels);
  assign stop_after = EW'(count_inc) >= EW'(cfg.frame_pixels);
  assign is_pixel = head.valid && (head.entry.kind == lcdpu_pkg::KIND_PIXEL);
  assign pal_mode = !cfg.pixel_mode[2];
  assign pal_we = head.valid && (head.entry.kind == lcdpu_pkg::KIND_PALWR);

  assign o_free = !o_valid || m_tready;
  assign p_ready = !p_valid || o_free;
  assign issue = is_pixel && in_frame && p_ready;
  assign pix_last = (k == head.entry.last_pix) || stop_after;
  assign pop = head.valid &&
               (!is_pixel || !in_frame || (p_ready && pix_last));

  // palette index of pixel k
  always_comb begin
    bpp = 4'd1 << cfg.pixel_mode[1:0];
    pos = 6'd32 - (({1'b0, k} + 6'd1) << cfg.pixel_mode[1:0]);
    sel = cfg.big_endian_bytes ? 5'd0 : 5'd24;
    if (!cfg.big_endian_pixels) begin
      sel = sel ^ (5'd8 - {1'b0, bpp});
    end
    bitpos = pos[4:0] ^ sel;
    shifted = head.entry.word >> bitpos;
    mask = 8'((9'd1 << bpp) - 9'd1);
    pal_idx = shifted[7:0] & mask;
  end

  // direct color of pixel k
  always_comb begin
    wsw = cfg.big_endian_bytes ? {head.entry.word[15:0], head.entry.word[31:16]}
                               : head.entry.word;
    half = k[0] ? wsw[31:16] : wsw[15:0];
    case (cfg.pixel_mode)
      lcdpu_pkg::MODE_1555: x_direct = lcdpu_pkg::from1555(half);
      lcdpu_pkg::MODE_888:  x_direct = lcdpu_pkg::from888(head.entry.word);
      lcdpu_pkg::MODE_565:  x_direct = half;
      lcdpu_pkg::MODE_444:  x_direct = lcdpu_pkg::from444(half);
      default:              x_direct = '0;
    endcase
  end

  lcdpu_ram #(
    .WIDTH(16),
    .DEPTH(lcdpu_pkg::PALETTE_DEPTH)
  ) u_palette (
    .clk(clk),
    .we(pal_we),
    .waddr(head.entry.pal_index),
    .wdata(head.entry.pal_value),
    .re(issue && pal_mode),
    .raddr(pal_idx),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
      count <= '0;
      pal_valid <= '0;
      p_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (issue) begin
        k <= pix_last ? '0 : k + lcdpu_pkg::NPIX_W'(1);
      end
      if (head.valid && (head.entry.kind == lcdpu_pkg::KIND_START)) begin
        count <= '0;
      end else if (issue) begin
        count <= count_inc;
      end
      if (pal_we) begin
        pal_valid[head.entry.pal_index] <= 1'b1;
      end
      if (p_ready) begin
        p_valid <= issue;
      end
      if (o_free) begin
        o_valid <= p_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p_pal <= pal_mode;
      p_pal_ok <= pal_valid[pal_idx];
      p_x <= x_direct;
      p_last <= pix_last;
    end
    if (o_free && p_valid) begin
      o_data <= cfg.rgb_order ? {b8, g8, r8} : {r8, g8, b8};
      o_last <= p_last;
    end
  end

  always_comb begin
    px = p_pal ? lcdpu_pkg::from1555(p_pal_ok ? ram_q : 16'h0000) : p_x;
    r8 = lcdpu_pkg::widen({px[15:11], px[15]});
    g8 = lcdpu_pkg::widen(px[10:5]);
    b8 = lcdpu_pkg::widen({px[4:0], px[4]});
  end

  assign m_tvalid = o_valid;
  assign m_tdata = o_data;
  assign m_tlast = o_last;
endmodule
`default_nettype wire

// ----- rtl/lcd_pixel_unpack_palette_core.sv -----
// top level of the lcd pixel unpack core with palette
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tuser action, tdata word/index/value
// m_*       out  m_tvalid/m_tready  tdata channels, tlast last of word or frame
// cfg_*     in   cfg_we             cfg_index, cfg_wdata
//
// one pixel per cycle leaves the back end unless the output stalls; a word gives
// 1 to 32 pixels, set by the pixel mode and cut at frame end; other items give none
// the first pixel of a word passes the queue slot, p stage and o stage to m_*
// rst is synchronous; it clears the queue, counter, palette valid bits, resets cfg
// the two-entry queue buffers up to two input transfers while the output stalls
`default_nettype none
`include "lcd_pixel_unpack_palette_core_defines.svh"
module lcd_pixel_unpack_palette_core #(
  parameter int unsigned COUNT_WIDTH = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // frame_word, palette_index, palette_value
  input  logic [1:0]  s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // first_channel, green_channel, third_channel
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_wdata
);
  lcdpu_pkg::cfg_t    cfg;
  lcdpu_pkg::qentry_t push_data;
  lcdpu_pkg::qhead_t  q_head;
  logic push;
  logic full;
  logic pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_mode <= '0;
      cfg.rgb_order <= 1'b0;
      cfg.big_endian_bytes <= 1'b0;
      cfg.big_endian_pixels <= 1'b0;
      cfg.frame_pixels <= lcdpu_pkg::FRAME_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lcdpu_pkg::REG_PIXEL_MODE:        cfg.pixel_mode <= cfg_wdata[2:0];
        lcdpu_pkg::REG_RGB_ORDER:         cfg.rgb_order <= cfg_wdata[0];
        lcdpu_pkg::REG_BIG_ENDIAN_BYTES:  cfg.big_endian_bytes <= cfg_wdata[0];
        lcdpu_pkg::REG_BIG_ENDIAN_PIXELS: cfg.big_endian_pixels <= cfg_wdata[0];
        lcdpu_pkg::REG_FRAME_PIXELS:      cfg.frame_pixels <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  lcdpu_front u_front (
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .pixel_mode(cfg.pixel_mode),
    .full(full),
    .push(push),
    .push_data(push_data)
  );

  lcdpu_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(push_data),
    .full(full),
    .pop(pop),
    .head(q_head)
  );

  lcdpu_back #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .head(q_head),
    .pop(pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  `LCDPU_ASSERT_IMPL(a_full_has_head, !s_tready, q_head.valid)
  `LCDPU_ASSERT_NEXT(a_transfer_fills_queue, s_tvalid && s_tready, q_head.valid)
  `LCDPU_ASSERT_NEXT(a_bad_index, cfg_we && cfg_index > lcdpu_pkg::REG_FRAME_PIXELS, $stable(cfg))
endmodule
`default_nettype wire
